[hw/rtl/sppc_pkg.sv]
// ----------------------------------------------------------------------------
// sppc_pkg
// Shared constants, types and the field decoder for the serial PWM command
// parser.
// ----------------------------------------------------------------------------
package sppc_pkg;

    // Collector sizing
    localparam int BUFFER_BYTES = 512;
    localparam int MAX_PAYLOAD  = 32;
    localparam int HEAD_DEPTH   = 10;
    localparam int MARK_LEN     = 8;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES);
    localparam int HEAD_IDX_W   = $clog2(HEAD_DEPTH);
    localparam int MARK_IDX_W   = $clog2(MARK_LEN);
    localparam int PROG_W       = $clog2(MARK_LEN + 1);

    // Bytes of the payload that feed the number fields (positions 2..9)
    localparam int FIELD_BYTES  = HEAD_DEPTH - 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Output packing
    localparam int PORT_W       = 8;
    localparam int DUTY_W       = 8;
    localparam int FREQ_W       = 15;
    localparam int OUT_TDATA_W  = 40;

    // Character codes
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Command marker "-prints:"
    localparam logic [7:0] MARK_TEXT [MARK_LEN] = '{
        8'h2D, 8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h73, 8'h3A
    };

    // One classified request handed from front to back
    typedef struct packed {
        logic                     cmd_ok;
        logic [FIELD_BYTES*8-1:0] fields;     // payload byte 2 in the low bits
        logic [7:0]               echo_byte;
    } t_cmd_entry;

    // Pop handshake driven by the back end into the queue
    typedef struct packed {
        logic pop_valid;
        logic pop_ready;
    } t_pop_ctrl;

    typedef enum logic [1:0] {
        ATOI_LEAD,
        ATOI_DIGITS,
        ATOI_DONE
    } t_atoi_phase;

    // Decimal decode of up to four bytes: leading white space, optional sign,
    // then digits until the first non-digit or the end of the field.
    function automatic logic [FREQ_W-1:0] decode_field(input logic [31:0] f,
                                                       input int n);
        t_atoi_phase     phase;
        logic            neg;
        logic [FREQ_W-1:0] v;
        logic [7:0]      c;
        logic            is_digit;
        logic            is_ws;
        phase = ATOI_LEAD;
        neg   = 1'b0;
        v     = '0;
        for (int i = 0; i < 4; i++) begin
            c        = f[i*8 +: 8];
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            is_ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
            if (i < n) begin
                case (phase)
                    ATOI_LEAD: begin
                        if (is_ws) begin
                            phase = ATOI_LEAD;
                        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                            neg   = (c == CHAR_MINUS);
                            phase = ATOI_DIGITS;
                        end else if (is_digit) begin
                            v     = FREQ_W'(c[3:0]);
                            phase = ATOI_DIGITS;
                        end else begin
                            phase = ATOI_DONE;
                        end
                    end
                    ATOI_DIGITS: begin
                        if (is_digit) begin
                            v = FREQ_W'(v * FREQ_W'(10)) + FREQ_W'(c[3:0]);
                        end else begin
                            phase = ATOI_DONE;
                        end
                    end
                    default: begin
                        phase = ATOI_DONE;
                    end
                endcase
            end
        end
        return neg ? FREQ_W'(-v) : v;
    endfunction

endpackage

[hw/rtl/sppc_front.sv]
// ----------------------------------------------------------------------------
// sppc_front
// Byte collector and marker matcher. Classifies each received byte and, on a
// semicolon, judges the command and clears the collector.
// ----------------------------------------------------------------------------
module sppc_front import sppc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output t_cmd_entry o_entry
);

    logic [COUNT_W-1:0] r_stored_count, n_stored_count;
    logic [PROG_W-1:0]  r_match_progress, n_match_progress;
    logic               r_match_found, n_match_found;
    logic [COUNT_W-1:0] r_payload_count, n_payload_count;
    logic [7:0]         r_head [HEAD_DEPTH];
    logic [7:0]         n_head [HEAD_DEPTH];

    logic               room;
    logic               is_semi;
    logic [COUNT_W-1:0] plen;
    logic [7:0]         pl [HEAD_DEPTH];
    logic               cmd_ok;

    assign room    = r_stored_count < COUNT_W'(BUFFER_BYTES - 1);
    assign is_semi = i_rx_byte == CHAR_SEMI;

    // Collector update for the current byte
    always_comb begin
        n_stored_count   = r_stored_count;
        n_match_progress = r_match_progress;
        n_match_found    = r_match_found;
        n_payload_count  = r_payload_count;
        for (int i = 0; i < HEAD_DEPTH; i++) begin
            n_head[i] = r_head[i];
        end
        if (room) begin
            n_stored_count = r_stored_count + 1'b1;
            if (r_match_found) begin
                if (r_payload_count < COUNT_W'(HEAD_DEPTH)) begin
                    n_head[r_payload_count[HEAD_IDX_W-1:0]] = i_rx_byte;
                end
                n_payload_count = r_payload_count + 1'b1;
            end else begin
                if (r_match_progress < PROG_W'(MARK_LEN) &&
                    i_rx_byte == MARK_TEXT[r_match_progress[MARK_IDX_W-1:0]]) begin
                    n_match_progress = r_match_progress + 1'b1;
                end else begin
                    n_match_progress = (i_rx_byte == MARK_TEXT[0]) ? PROG_W'(1) : '0;
                end
                if (n_match_progress >= PROG_W'(MARK_LEN)) begin
                    n_match_found = 1'b1;
                end
            end
        end
    end

    // Judge: payload excludes the last stored byte; unused positions read zero
    assign plen = n_payload_count - 1'b1;

    always_comb begin
        for (int i = 0; i < HEAD_DEPTH; i++) begin
            pl[i] = (COUNT_W'(i) < plen) ? n_head[i] : 8'h00;
        end
    end

    assign cmd_ok = is_semi && n_match_found
                    && (n_payload_count >= COUNT_W'(2))
                    && (plen < COUNT_W'(MAX_PAYLOAD))
                    && (plen >= COUNT_W'(8))
                    && (pl[0] == CHAR_A) && (pl[1] == CHAR_A);

    always_comb begin
        o_entry.echo_byte = i_rx_byte;
        o_entry.cmd_ok    = cmd_ok;
        for (int i = 0; i < FIELD_BYTES; i++) begin
            o_entry.fields[i*8 +: 8] = pl[i+2];
        end
    end

    // Collector state; a semicolon clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_count   <= '0;
            r_match_progress <= '0;
            r_match_found    <= 1'b0;
            r_payload_count  <= '0;
        end else if (i_accept) begin
            if (is_semi) begin
                r_stored_count   <= '0;
                r_match_progress <= '0;
                r_match_found    <= 1'b0;
                r_payload_count  <= '0;
            end else begin
                r_stored_count   <= n_stored_count;
                r_match_progress <= n_match_progress;
                r_match_found    <= n_match_found;
                r_payload_count  <= n_payload_count;
            end
        end
    end

    // Head bytes are always written before they are read back
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                r_head[i] <= n_head[i];
            end
        end
    end

endmodule

[hw/rtl/sppc_queue.sv]
// ----------------------------------------------------------------------------
// sppc_queue
// Small request queue between the front and the back end.
// ----------------------------------------------------------------------------
module sppc_queue import sppc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd_entry i_push_entry,
    output logic       o_push_ready,
    input  t_pop_ctrl  i_pop,
    output logic       o_pop_valid,
    output t_cmd_entry o_pop_entry
);

    t_cmd_entry        r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_entry  = r_slot[r_rd_ptr];

    assign do_push = i_push && o_push_ready;
    assign do_pop  = i_pop.pop_valid && i_pop.pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/sppc_back.sv]
// ----------------------------------------------------------------------------
// sppc_back
// Decodes the number fields of a judged request and holds the result in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module sppc_back import sppc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_entry_valid,
    input  t_cmd_entry             i_entry,
    output t_pop_ctrl              o_pop,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tuser
);

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_tdata;
    logic                   r_tuser;

    logic                   load;
    logic [FREQ_W-1:0]      port_raw;
    logic [FREQ_W-1:0]      duty_raw;
    logic [FREQ_W-1:0]      freq_raw;
    logic [PORT_W-1:0]      port_val;
    logic [DUTY_W-1:0]      duty_val;
    logic [FREQ_W-1:0]      freq_val;

    assign load = i_entry_valid && (!r_valid || i_tready);

    assign o_pop.pop_valid = i_entry_valid;
    assign o_pop.pop_ready = !r_valid || i_tready;

    // Field decode: port = bytes 2-3, duty = 4-5, frequency = 6-9
    assign port_raw = decode_field({16'h0000, i_entry.fields[15:0]}, 2);
    assign duty_raw = decode_field({16'h0000, i_entry.fields[31:16]}, 2);
    assign freq_raw = decode_field(i_entry.fields[63:32], 4);

    assign port_val = i_entry.cmd_ok ? port_raw[PORT_W-1:0] : '0;
    assign duty_val = i_entry.cmd_ok ? duty_raw[DUTY_W-1:0] : '0;
    assign freq_val = i_entry.cmd_ok ? freq_raw : '0;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tdata <= {1'b0, freq_val, duty_val, port_val, i_entry.echo_byte};
            r_tuser <= i_entry.cmd_ok;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;

endmodule

[hw/rtl/serial_pwm_command_parser.sv]
// ----------------------------------------------------------------------------
// serial_pwm_command_parser
// Echoes every received byte and decodes "-prints:AA<port><duty><freq>;"
// commands into PWM settings.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per request in tdata[7:0].
//   m_axis returns exactly one result per input byte, in order:
//     tdata[7:0]   echoed byte
//     tdata[15:8]  port, signed
//     tdata[23:16] duty in hundredths, signed
//     tdata[38:24] frequency, signed (bit 39 is zero)
//     tuser        1 when this byte (a ';') closed a valid AA command;
//                  the number fields are zero otherwise.
//   An accepted byte is queued, then loaded into the output register once it
//   is free. Throughput: one byte per cycle while m_axis_tready is high, set
//   by the collector update in the front end and the single output register.
//   Reset (i_rst_n low, synchronous) clears the collector, the four-entry
//   request queue and the output register.
//   When the receiver stalls, up to four requests plus the held result are
//   absorbed; s_axis_tready then drops until the back end takes a request
//   from the queue.
// ----------------------------------------------------------------------------
module serial_pwm_command_parser import sppc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] echo_byte, [15:8] pwm_port,
                                                   // [23:16] duty_hundredths,
                                                   // [38:24] pwm_frequency
    output logic                   m_axis_tuser    // [0] command_valid
);

    logic       accept;
    logic       push_ready;
    t_cmd_entry front_entry;
    t_cmd_entry queue_entry;
    logic       queue_valid;
    t_pop_ctrl  pop_ctrl;

    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && push_ready;

    // Front end: collect and classify
    sppc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (s_axis_tdata),
        .o_entry   (front_entry)
    );

    // Request queue
    sppc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept),
        .i_push_entry (front_entry),
        .o_push_ready (push_ready),
        .i_pop        (pop_ctrl),
        .o_pop_valid  (queue_valid),
        .o_pop_entry  (queue_entry)
    );

    // Back end: decode and output
    sppc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (queue_valid),
        .i_entry       (queue_entry),
        .o_pop         (pop_ctrl),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_tdata       (m_axis_tdata),
        .o_tuser       (m_axis_tuser)
    );

endmodule
